[sv/sxyz_pkg.sv]
// Package: shared constants, float type and helper functions for the sRGB to XYZ converter.
package sxyz_pkg;

   localparam int CHAN_W    = 16;
   localparam int TRI_W     = 15;
   localparam int CHROMA_W  = 16;

   // sRGB curve: linear segment limit and reciprocal for the divide by 646
   localparam logic [15:0] LIN_LIMIT  = 16'd2650;
   localparam logic [21:0] LIN_MUL    = 22'd50;
   localparam logic [21:0] LIN_BIAS   = 22'd323;
   localparam logic [40:0] LIN_RECIP  = 41'd415535;
   localparam logic [26:0] POW_MUL    = 27'd1000;
   localparam logic [26:0] POW_BIAS   = 27'd3604425;
   localparam logic [31:0] POW_DEN    = 32'd69139425;

   localparam logic [15:0] MAT [3][3] = '{
      '{16'd27031, 16'd23434, 16'd11825},
      '{16'd13938, 16'd46868, 16'd4730},
      '{16'd1267,  16'd7811,  16'd62279}
   };

   localparam logic [46:0] TRI_SCALE = 47'd25600;
   localparam logic [46:0] TRI_BIAS  = 47'd2147450880;
   localparam logic [16:0] TRI_DIV   = 17'd65535;
   localparam logic [15:0] TRI_MAX   = 16'd32767;

   // pipeline depths
   localparam int SRCH_BITS = 16;
   localparam int DEC_LAT   = 7 + 4 * SRCH_BITS + 1;
   localparam int DIV_LAT   = 17;
   localparam int MAT_LAT   = 5;
   localparam int PIPE_LAT  = 1 + DEC_LAT + MAT_LAT + DIV_LAT + 1;

   // value = m * 2^e, m normalized with bit 31 set
   typedef struct packed {
      logic signed [11:0] e;
      logic [31:0]        m;
   } fp_type;

   function automatic fp_type to_float(logic [31:0] x);
      fp_type r;
      int     msb;
      begin
         msb = 0;
         for (int i = 0; i < 32; i++) begin
            if (x[i]) msb = i;
         end
         r.m = x << (31 - msb);
         r.e = 12'(msb - 31);
         return r;
      end
   endfunction

   function automatic fp_type fmul(fp_type a, fp_type b);
      logic [63:0] p;
      fp_type      r;
      begin
         p = a.m * b.m;
         if (p[63]) begin
            r.m = p[63:32];
            r.e = a.e + b.e + 12'sd32;
         end else begin
            r.m = p[62:31];
            r.e = a.e + b.e + 12'sd31;
         end
         return r;
      end
   endfunction

   function automatic logic fle(fp_type a, fp_type b);
      return (a.e < b.e) || ((a.e == b.e) && (a.m <= b.m));
   endfunction

   function automatic fp_type fpow(logic [31:0] x, int n);
      fp_type b;
      fp_type r;
      begin
         b = to_float(x);
         r = b;
         for (int i = 1; i < n; i++) r = fmul(r, b);
         return r;
      end
   endfunction

   // compare (2w-1)^5 * d^12 against 32 * 65535^5 * a^12
   localparam fp_type D_FP = fpow(POW_DEN, 12);
   localparam fp_type K_FP = fmul(to_float(32'd32), fpow(32'd65535, 5));

endpackage

[sv/sxyz_ifs.sv]
// Interfaces: pixel request channel and XYZ/xyY response channel.
interface sxyz_req_if;
   logic        valid;
   logic        ready;
   logic [15:0] red;
   logic [15:0] green;
   logic [15:0] blue;
   modport source(output valid, output red, output green, output blue, input ready);
   modport sink(input valid, input red, input green, input blue, output ready);
endinterface

interface sxyz_rsp_if;
   logic        valid;
   logic        ready;
   logic [14:0] cie_x;
   logic [14:0] cie_y;
   logic [14:0] cie_z;
   logic [15:0] chroma_x;
   logic [15:0] chroma_y;
   modport source(output valid, output cie_x, output cie_y, output cie_z,
                  output chroma_x, output chroma_y, input ready);
   modport sink(input valid, input cie_x, input cie_y, input cie_z,
                input chroma_x, input chroma_y, output ready);
endinterface

[sv/srgb_to_xyz_xyy.sv]
// Top level: sRGB pixel to CIE XYZ (D65) and xyY chromaticity converter.
//  channel    modport  fields                                  handshake
//  req_chan   sink     red, green, blue                         valid/ready
//  rsp_chan   source   cie_x, cie_y, cie_z, chroma_x, chroma_y  valid/ready
// One pixel enters per cycle while the pipeline is not held; results come out in input order.
// Latency is set by the curve decode: a 16-bit search, four stages per bit.
// The whole pipeline advances together; it holds while a result waits on rsp_chan.
// Reset clears only the valid bits.
module srgb_to_xyz_xyy (
   input  logic              clock,
   input  logic              reset,
   sxyz_req_if.sink          req_chan,
   sxyz_rsp_if.source        rsp_chan
);

   localparam int LAT = sxyz_pkg::PIPE_LAT;
   localparam int DL  = sxyz_pkg::DIV_LAT;

   logic        vld_ff [LAT];
   logic        adv;
   logic [15:0] pix_ff [3];
   logic [15:0] lin    [3];
   logic [31:0] prod_ff [3][3];
   logic [33:0] rsum_ff [3];
   logic [30:0] m_ff    [3];
   logic [14:0] tri_ff  [3];
   logic [14:0] tri_in  [3];
   logic [16:0] sum_ff;
   logic [14:0] tx_ff [DL+1], ty_ff [DL+1], tz_ff [DL+1];
   logic        zero_ff [DL+1];
   logic [15:0] qx, qy;
   logic [14:0] ox_ff, oy_ff, oz_ff;
   logic [15:0] chx_ff, chy_ff;

   assign adv            = !vld_ff[LAT-1] || rsp_chan.ready;
   assign req_chan.ready = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < LAT; i++) vld_ff[i] <= 1'b0;
      end else if (adv) begin
         vld_ff[0] <= req_chan.valid;
         for (int i = 1; i < LAT; i++) vld_ff[i] <= vld_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         pix_ff[0] <= req_chan.red;
         pix_ff[1] <= req_chan.green;
         pix_ff[2] <= req_chan.blue;
      end
   end

   genvar gc;
   generate
      for (gc = 0; gc < 3; gc++) begin : g_dec
         sxyz_decode u_dec (
            .clock   (clock),
            .adv     (adv),
            .code    (pix_ff[gc]),
            .lin_out (lin[gc])
         );
      end
   endgenerate

   // matrix, scaling to 1/256 percent: n / 65536 / 65535, last step by fold and correct
   always_comb begin
      logic [14:0] q0;
      logic [16:0] rem;
      logic [15:0] q;
      for (int r = 0; r < 3; r++) begin
         q0  = m_ff[r][30:16];
         rem = 17'(m_ff[r][15:0]) + 17'(q0);
         q   = 16'(q0) + 16'(rem >= sxyz_pkg::TRI_DIV);
         tri_in[r] = (q > sxyz_pkg::TRI_MAX) ? sxyz_pkg::TRI_MAX[14:0] : q[14:0];
      end
   end

   always_ff @(posedge clock) begin
      logic [46:0] n;
      if (adv) begin
         for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) prod_ff[r][c] <= lin[c] * sxyz_pkg::MAT[r][c];
            rsum_ff[r] <= 34'(prod_ff[r][0]) + 34'(prod_ff[r][1]) + 34'(prod_ff[r][2]);
            n = {13'd0, rsum_ff[r]} * sxyz_pkg::TRI_SCALE + sxyz_pkg::TRI_BIAS;
            m_ff[r]   <= n[46:16];
            tri_ff[r] <= tri_in[r];
         end
         sum_ff <= 17'(tri_ff[0]) + 17'(tri_ff[1]) + 17'(tri_ff[2]);
      end
   end

   // carry the tristimulus values alongside the dividers
   always_ff @(posedge clock) begin
      if (adv) begin
         tx_ff[0]   <= tri_ff[0];
         ty_ff[0]   <= tri_ff[1];
         tz_ff[0]   <= tri_ff[2];
         zero_ff[0] <= (17'(tri_ff[0]) + 17'(tri_ff[1]) + 17'(tri_ff[2])) == 17'd0;
         for (int i = 1; i <= DL; i++) begin
            tx_ff[i]   <= tx_ff[i-1];
            ty_ff[i]   <= ty_ff[i-1];
            tz_ff[i]   <= tz_ff[i-1];
            zero_ff[i] <= zero_ff[i-1];
         end
      end
   end

   sxyz_div u_div_x (
      .clock (clock),
      .adv   (adv),
      .part  (tx_ff[0]),
      .sum   (sum_ff),
      .quo   (qx)
   );

   sxyz_div u_div_y (
      .clock (clock),
      .adv   (adv),
      .part  (ty_ff[0]),
      .sum   (sum_ff),
      .quo   (qy)
   );

   always_ff @(posedge clock) begin
      if (adv) begin
         ox_ff  <= tx_ff[DL];
         oy_ff  <= ty_ff[DL];
         oz_ff  <= tz_ff[DL];
         chx_ff <= zero_ff[DL] ? 16'd0 : qx;
         chy_ff <= zero_ff[DL] ? 16'd0 : qy;
      end
   end

   assign rsp_chan.valid    = vld_ff[LAT-1];
   assign rsp_chan.cie_x    = ox_ff;
   assign rsp_chan.cie_y    = oy_ff;
   assign rsp_chan.cie_z    = oz_ff;
   assign rsp_chan.chroma_x = chx_ff;
   assign rsp_chan.chroma_y = chy_ff;

endmodule

[sv/sxyz_decode.sv]
// sRGB transfer curve decode of one channel to Q0.16, pipelined.
module sxyz_decode (
   input  logic        clock,
   input  logic        adv,
   input  logic [15:0] code,
   output logic [15:0] lin_out
);

   localparam int SRCH_BITS_L = sxyz_pkg::SRCH_BITS;

   typedef struct packed {
      sxyz_pkg::fp_type rhs;
      logic [15:0]      w;
      logic [7:0]       lin;
      logic             islin;
   } hd_type;

   typedef struct packed {
      hd_type           h;
      sxyz_pkg::fp_type cf;
      sxyz_pkg::fp_type c2;
      sxyz_pkg::fp_type cd;
      sxyz_pkg::fp_type c4;
   } srch_type;

   logic [26:0]      a_ff;
   sxyz_pkg::fp_type af_ff, a2_ff, a4_ff, a4k_ff, a8_ff, a12_ff, rhs_ff;
   logic [7:0]       lin_p_ff [1:7];
   logic             islin_p_ff [1:7];
   logic [21:0]      n_in;
   logic [40:0]      prod_in;
   hd_type           head;
   srch_type         s0_ff [SRCH_BITS_L];
   srch_type         s1_ff [SRCH_BITS_L];
   srch_type         s2_ff [SRCH_BITS_L];
   srch_type         s3_ff [SRCH_BITS_L];
   logic [15:0]      lin_out_ff;

   always_comb begin
      n_in    = {6'd0, code} * sxyz_pkg::LIN_MUL + sxyz_pkg::LIN_BIAS;
      prod_in = {19'd0, n_in} * sxyz_pkg::LIN_RECIP;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         a_ff          <= {11'd0, code} * sxyz_pkg::POW_MUL + sxyz_pkg::POW_BIAS;
         lin_p_ff[1]   <= prod_in[35:28];
         islin_p_ff[1] <= (code <= sxyz_pkg::LIN_LIMIT);
         af_ff         <= sxyz_pkg::to_float({5'd0, a_ff});
         a2_ff         <= sxyz_pkg::fmul(af_ff, af_ff);
         a4_ff         <= sxyz_pkg::fmul(a2_ff, a2_ff);
         a8_ff         <= sxyz_pkg::fmul(a4_ff, a4_ff);
         a4k_ff        <= a4_ff;
         a12_ff        <= sxyz_pkg::fmul(a8_ff, a4k_ff);
         rhs_ff        <= sxyz_pkg::fmul(a12_ff, sxyz_pkg::K_FP);
         for (int i = 2; i <= 7; i++) begin
            lin_p_ff[i]   <= lin_p_ff[i-1];
            islin_p_ff[i] <= islin_p_ff[i-1];
         end
      end
   end

   always_comb begin
      head.rhs   = rhs_ff;
      head.w     = '0;
      head.lin   = lin_p_ff[7];
      head.islin = islin_p_ff[7];
   end

   // one result bit per group of four stages, MSB first
   genvar gb;
   generate
      for (gb = 0; gb < SRCH_BITS_L; gb++) begin : g_bit
         localparam logic [15:0] BIT = 16'd1 << (SRCH_BITS_L - 1 - gb);
         hd_type      prev;
         logic [15:0] t;
         logic [16:0] c;
         srch_type    s0_in, s1_in, s2_in, s3_in;

         if (gb == 0) begin : g_first
            assign prev = head;
         end else begin : g_next
            assign prev = s3_ff[gb-1].h;
         end

         always_comb begin
            s0_in    = '0;
            s0_in.h  = prev;
            t        = prev.w | BIT;
            c        = {t, 1'b0} - 17'd1;
            s0_in.cf = sxyz_pkg::to_float({15'd0, c});
            s1_in    = s0_ff[gb];
            s1_in.c2 = sxyz_pkg::fmul(s0_ff[gb].cf, s0_ff[gb].cf);
            s1_in.cd = sxyz_pkg::fmul(s0_ff[gb].cf, sxyz_pkg::D_FP);
            s2_in    = s1_ff[gb];
            s2_in.c4 = sxyz_pkg::fmul(s1_ff[gb].c2, s1_ff[gb].c2);
            s3_in    = s2_ff[gb];
            if (sxyz_pkg::fle(sxyz_pkg::fmul(s2_ff[gb].c4, s2_ff[gb].cd), s2_ff[gb].h.rhs))
               s3_in.h.w = s2_ff[gb].h.w | BIT;
         end

         always_ff @(posedge clock) begin
            if (adv) begin
               s0_ff[gb] <= s0_in;
               s1_ff[gb] <= s1_in;
               s2_ff[gb] <= s2_in;
               s3_ff[gb] <= s3_in;
            end
         end
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (adv) begin
         lin_out_ff <= s3_ff[SRCH_BITS_L-1].h.islin ? {8'd0, s3_ff[SRCH_BITS_L-1].h.lin}
                                                  : s3_ff[SRCH_BITS_L-1].h.w;
      end
   end

   assign lin_out = lin_out_ff;

endmodule

[sv/sxyz_div.sv]
// Pipelined restoring divider for chromaticity: floor(part * 65536 / sum), saturated.
module sxyz_div (
   input  logic        clock,
   input  logic        adv,
   input  logic [14:0] part,
   input  logic [16:0] sum,
   output logic [15:0] quo
);

   localparam int NST = sxyz_pkg::DIV_LAT;

   logic [16:0] rem_ff [NST];
   logic [16:0] q_ff   [NST];
   logic [16:0] den_ff [NST];

   genvar gi;
   generate
      for (gi = 0; gi < NST; gi++) begin : g_st
         logic [16:0] rem_prev, q_prev, den_prev, rem_in;
         logic [17:0] r2;
         logic        ge;

         if (gi == 0) begin : g_first
            assign rem_prev = {3'd0, part[14:1]};
            assign q_prev   = '0;
            assign den_prev = sum;
            assign r2       = {rem_prev, part[0]};
         end else begin : g_next
            assign rem_prev = rem_ff[gi-1];
            assign q_prev   = q_ff[gi-1];
            assign den_prev = den_ff[gi-1];
            assign r2       = {rem_prev, 1'b0};
         end

         always_comb begin
            ge     = (r2 >= {1'b0, den_prev});
            rem_in = ge ? 17'(r2 - {1'b0, den_prev}) : r2[16:0];
         end

         always_ff @(posedge clock) begin
            if (adv) begin
               rem_ff[gi] <= rem_in;
               q_ff[gi]   <= {q_prev[15:0], ge};
               den_ff[gi] <= den_prev;
            end
         end
      end
   endgenerate

   assign quo = q_ff[NST-1][16] ? 16'hFFFF : q_ff[NST-1][15:0];

endmodule

[test/testbench.sv]
// Testbench for srgb_to_xyz_xyy: directed table and random pixels, checked by a predictor.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NUM_RANDOM  = 1880;
   localparam int CYCLE_LIMIT = 1000000;

   typedef struct packed {
      logic [15:0] red;
      logic [15:0] green;
      logic [15:0] blue;
   } pixel_type;

   typedef struct packed {
      logic [14:0] cie_x;
      logic [14:0] cie_y;
      logic [14:0] cie_z;
      logic [15:0] chroma_x;
      logic [15:0] chroma_y;
   } xyz_type;

   typedef struct {
      pixel_type pix;
      bit        typed;
      xyz_type   result;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   sxyz_req_if req_chan ();
   sxyz_rsp_if rsp_chan ();

   srgb_to_xyz_xyy i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan.sink),
      .rsp_chan (rsp_chan.source)
   );

   pixel_type    pixels[$];
   stim_row_type table_rows[$];
   xyz_type      expected_xyz[$];
   bit           typed_flags[$];
   xyz_type      typed_results[$];
   logic [15:0]  curve_cache[int];
   int           errors = 0;
   int           sent = 0;
   int           received = 0;
   bit           long_hold_done = 0;

   initial begin
      forever #4 clock = ~clock;
   end

   // exact sRGB curve, Q0.16, rounded half up
   function automatic logic [15:0] srgb_decode(logic [15:0] v);
      logic [511:0] rhs, dpow, t;
      logic [63:0]  a, d, fs, q;
      int           lo, hi, mid;
      fs = 64'd65535;
      if (curve_cache.exists(v)) return curve_cache[v];
      if (64'(v) * 64'd100000 <= fs * 64'd4045) begin
         q = (64'(v) * 64'd13107000 + 64'd1292 * fs) / (64'd2584 * fs);
         curve_cache[v] = q[15:0];
         return q[15:0];
      end
      a = 64'd1000 * 64'(v) + 64'd55 * fs;
      d = 64'd1055 * fs;
      rhs = 512'd32;
      for (int i = 0; i < 5; i++) rhs = rhs * 512'd65535;
      for (int i = 0; i < 12; i++) rhs = rhs * 512'(a);
      dpow = 512'd1;
      for (int i = 0; i < 12; i++) dpow = dpow * 512'(d);
      lo = 0;
      hi = 65535;
      while (lo < hi) begin
         mid = (lo + hi + 1) / 2;
         t = dpow;
         for (int i = 0; i < 5; i++) t = t * 512'(2 * mid - 1);
         if (t <= rhs) lo = mid;
         else hi = mid - 1;
      end
      curve_cache[v] = 16'(lo);
      return 16'(lo);
   endfunction

   function automatic logic [15:0] chroma_ratio(logic [31:0] part, logic [31:0] sum);
      logic [63:0] q;
      if (sum == 0) return 16'd0;
      q = (64'(part) << 16) / 64'(sum);
      return (q > 64'd65535) ? 16'hFFFF : q[15:0];
   endfunction

   function automatic xyz_type xyz_predict(pixel_type p);
      logic [15:0] lin[3];
      logic [31:0] tri_val[3];
      logic [63:0] s, q;
      logic [31:0] sum;
      xyz_type     r;
      lin[0] = srgb_decode(p.red);
      lin[1] = srgb_decode(p.green);
      lin[2] = srgb_decode(p.blue);
      for (int row = 0; row < 3; row++) begin
         s = 0;
         for (int c = 0; c < 3; c++) s += 64'(sxyz_pkg::MAT[row][c]) * 64'(lin[c]);
         q = (s * 64'd25600 + 64'd2147450880) / 64'd4294901760;
         tri_val[row] = (q > 64'd32767) ? 32'd32767 : q[31:0];
      end
      sum = tri_val[0] + tri_val[1] + tri_val[2];
      r.cie_x = tri_val[0][14:0];
      r.cie_y = tri_val[1][14:0];
      r.cie_z = tri_val[2][14:0];
      r.chroma_x = chroma_ratio(tri_val[0], sum);
      r.chroma_y = chroma_ratio(tri_val[1], sum);
      return r;
   endfunction

   function automatic logic [15:0] random_channel();
      int pick;
      pick = $urandom_range(0, 9);
      case (pick)
         0: return 16'($urandom_range(2600, 2700));    // around the curve knee
         1: return 16'($urandom_range(0, 40));
         2: return 16'($urandom_range(65495, 65535));
         3: return 16'(1) << $urandom_range(0, 15);
         4: return ~(16'(1) << $urandom_range(0, 15));
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic int random_gap();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 70) return 0;
      if (pick < 95) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   function automatic stim_row_type row(logic [15:0] r, logic [15:0] g, logic [15:0] b);
      stim_row_type s;
      s.pix = '{red: r, green: g, blue: b};
      s.typed = 0;
      s.result = '0;
      return s;
   endfunction

   initial begin
      stim_row_type s;
      pixel_type    p;
      // black: everything zero, including the zero-sum chromaticity
      s = row(16'd0, 16'd0, 16'd0);
      s.typed = 1;
      table_rows.push_back(s);
      table_rows.push_back(row(16'hFFFF, 16'hFFFF, 16'hFFFF));
      table_rows.push_back(row(16'hFFFF, 16'd0, 16'd0));
      table_rows.push_back(row(16'd0, 16'hFFFF, 16'd0));
      table_rows.push_back(row(16'd0, 16'd0, 16'hFFFF));
      table_rows.push_back(row(16'd1, 16'd1, 16'd1));
      table_rows.push_back(row(16'd1, 16'd0, 16'd0));
      table_rows.push_back(row(16'd0, 16'd0, 16'd1));
      table_rows.push_back(row(16'd2650, 16'd2651, 16'd2649));
      table_rows.push_back(row(16'd2651, 16'd2650, 16'd2652));
      table_rows.push_back(row(16'hAAAA, 16'h5555, 16'hAAAA));
      table_rows.push_back(row(16'h5555, 16'hAAAA, 16'h5555));
      table_rows.push_back(row(16'h8000, 16'h8000, 16'h8000));
      table_rows.push_back(row(16'hFFFE, 16'h7FFF, 16'd2));
      table_rows.push_back(row(16'd0, 16'hFFFF, 16'hFFFF));
      table_rows.push_back(row(16'hFFFF, 16'd0, 16'hFFFF));
      foreach (table_rows[i]) begin
         pixels.push_back(table_rows[i].pix);
      end
      for (int i = 0; i < NUM_RANDOM; i++) begin
         if ($urandom_range(0, 7) == 0) begin
            // gray pixels
            p.red   = random_channel();
            p.green = p.red;
            p.blue  = p.red;
         end else begin
            p.red   = random_channel();
            p.green = random_channel();
            p.blue  = random_channel();
         end
         pixels.push_back(p);
      end
   end

   // request side
   initial begin
      int gap;
      int quiet;
      req_chan.valid = 1'b0;
      req_chan.red   = '0;
      req_chan.green = '0;
      req_chan.blue  = '0;
      gap = 0;
      quiet = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      forever begin
         @(posedge clock);
         if (req_chan.valid && req_chan.ready) begin
            pixel_type p;
            p = '{red: req_chan.red, green: req_chan.green, blue: req_chan.blue};
            expected_xyz.push_back(xyz_predict(p));
            if (sent < table_rows.size()) begin
               typed_flags.push_back(table_rows[sent].typed);
               typed_results.push_back(table_rows[sent].result);
            end else begin
               typed_flags.push_back(0);
               typed_results.push_back('0);
            end
            sent++;
            if (sent % 300 == 0) quiet = $urandom_range(0, 1) ? 150 : 0;
            gap = (quiet > 0) ? 0 : random_gap();
         end
         if (!req_chan.valid || req_chan.ready) begin
            if (quiet > 0) quiet--;
            if (sent >= pixels.size() || gap > 0) begin
               if (gap > 0) gap--;
               req_chan.valid <= 1'b0;
            end else begin
               req_chan.valid <= 1'b1;
               req_chan.red   <= pixels[sent].red;
               req_chan.green <= pixels[sent].green;
               req_chan.blue  <= pixels[sent].blue;
            end
         end
      end
   end

   // response side: random stalls plus one long hold-off
   initial begin
      int hold;
      rsp_chan.ready = 1'b0;
      hold = 0;
      forever begin
         @(posedge clock);
         if (!long_hold_done && received >= 400) begin
            long_hold_done = 1;
            hold = 400;
         end
         if (hold > 0) begin
            hold--;
            rsp_chan.ready <= 1'b0;
         end else if (received % 250 < 60) begin
            rsp_chan.ready <= 1'b1;
         end else begin
            hold = random_gap();
            rsp_chan.ready <= (hold == 0);
         end
      end
   end

   // result checker
   initial begin
      xyz_type want, got;
      bit      typed;
      xyz_type typed_want;
      forever begin
         @(posedge clock);
         if (!reset && rsp_chan.valid && rsp_chan.ready) begin
            got = '{cie_x: rsp_chan.cie_x, cie_y: rsp_chan.cie_y, cie_z: rsp_chan.cie_z,
                    chroma_x: rsp_chan.chroma_x, chroma_y: rsp_chan.chroma_y};
            received++;
            if (expected_xyz.size() == 0) begin
               $error("unexpected transaction: cie_x=%0d cie_y=%0d cie_z=%0d",
                      got.cie_x, got.cie_y, got.cie_z);
               errors++;
            end else begin
               want = expected_xyz.pop_front();
               typed = typed_flags.pop_front();
               typed_want = typed_results.pop_front();
               if (typed && typed_want != want) begin
                  $error("predictor disagrees with table row %0d", received - 1);
                  errors++;
               end
               if (got.cie_x != want.cie_x) begin
                  $error("cie_x: expected %0d, actual %0d", want.cie_x, got.cie_x);
                  errors++;
               end
               if (got.cie_y != want.cie_y) begin
                  $error("cie_y: expected %0d, actual %0d", want.cie_y, got.cie_y);
                  errors++;
               end
               if (got.cie_z != want.cie_z) begin
                  $error("cie_z: expected %0d, actual %0d", want.cie_z, got.cie_z);
                  errors++;
               end
               if (got.chroma_x != want.chroma_x) begin
                  $error("chroma_x: expected %0d, actual %0d", want.chroma_x, got.chroma_x);
                  errors++;
               end
               if (got.chroma_y != want.chroma_y) begin
                  $error("chroma_y: expected %0d, actual %0d", want.chroma_y, got.chroma_y);
                  errors++;
               end
            end
         end
      end
   end

   // end of run
   initial begin
      int cycles;
      cycles = 0;
      while (!(pixels.size() > 0 && sent >= pixels.size() && expected_xyz.size() == 0)
             && cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      if (cycles >= CYCLE_LIMIT) begin
         $display("Test completed with failures");
      end else begin
         repeat (sxyz_pkg::PIPE_LAT + 20) @(posedge clock);
         if (errors == 0 && expected_xyz.size() == 0) begin
            $display("Test completed successfully");
         end else begin
            $display("Test completed with failures");
         end
      end
      $finish;
   end

endmodule
